// File: hw/rtl/b64enc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64enc_pkg
// Shared types, constants and the sextet-to-ASCII map for the base64 encoder.
// ----------------------------------------------------------------------------
package b64enc_pkg;

  // Default depth of the group queue between front and back
  localparam int unsigned QueueDepth = 2;

  // '=' padding character
  localparam logic [7:0] PadChar = 8'h3D;

  // Input beat: one raw message byte
  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_message;
  } in_beat_t;

  // Output beat: one encoded character
  typedef struct packed {
    logic [7:0] out_char;
    logic       last_char;
  } out_beat_t;

  // One 3-byte group, zero-filled when partial
  typedef struct packed {
    logic [23:0] bits;      // b0, b1, b2 from MSB down
    logic [1:0]  pad_cnt;   // trailing '=' characters (0..2)
    logic        last;      // group closes the message
  } group_t;

  // Back-end status for checking
  typedef struct packed {
    logic       pop;
    logic [1:0] char_idx;
  } back_stat_t;

  // Standard alphabet: A-Z, a-z, 0-9, '+', '/'
  function automatic logic [7:0] sextet_char(input logic [5:0] v);
    logic [7:0] ch;
    ch = 8'h2F;
    if (v < 6'd26) begin
      ch = 8'h41 + {2'b00, v};
    end else if (v < 6'd52) begin
      ch = 8'h61 + {2'b00, v - 6'd26};
    end else if (v < 6'd62) begin
      ch = 8'h30 + {2'b00, v - 6'd52};
    end else if (v == 6'd62) begin
      ch = 8'h2B;
    end
    return ch;
  endfunction

endpackage

// File: hw/rtl/b64enc_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// b64enc_front
// Accepts message bytes, holds up to two pending bytes and pushes complete or
// final (zero-filled) groups into the queue.
// ----------------------------------------------------------------------------
module b64enc_front (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output      logic                in_ready_o,
  input  wire b64enc_pkg::in_beat_t in_beat_i,
  output      logic                push_o,
  output      b64enc_pkg::group_t  push_group_o,
  input  wire logic                full_i
);

  logic [1:0] cnt_q, cnt_d;
  logic [7:0] pend0_q, pend0_d;
  logic [7:0] pend1_q, pend1_d;
  logic       accept;
  logic [7:0] b;
  logic       eom;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && !full_i;
  assign b          = in_beat_i.data_byte;
  assign eom        = in_beat_i.end_of_message;

  // Group assembly and pending-byte update
  always_comb begin
    cnt_d        = cnt_q;
    pend0_d      = pend0_q;
    pend1_d      = pend1_q;
    push_o       = 1'b0;
    push_group_o = '0;
    if (accept) begin
      if (cnt_q >= 2'd2) begin
        push_o               = 1'b1;
        push_group_o.bits    = {pend0_q, pend1_q, b};
        push_group_o.pad_cnt = 2'd0;
        push_group_o.last    = eom;
        cnt_d                = 2'd0;
      end else if (eom) begin
        push_o            = 1'b1;
        push_group_o.last = 1'b1;
        if (cnt_q == 2'd0) begin
          push_group_o.bits    = {b, 16'h0000};
          push_group_o.pad_cnt = 2'd2;
        end else begin
          push_group_o.bits    = {pend0_q, b, 8'h00};
          push_group_o.pad_cnt = 2'd1;
        end
        cnt_d = 2'd0;
      end else begin
        if (cnt_q == 2'd0) begin
          pend0_d = b;
        end else begin
          pend1_d = b;
        end
        cnt_d = cnt_q + 2'd1;
      end
    end
  end

  // Pending count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // Held bytes (payload, no reset)
  always_ff @(posedge clk_i) begin
    pend0_q <= pend0_d;
    pend1_q <= pend1_d;
  end

endmodule
`default_nettype wire

// File: hw/rtl/b64enc_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// b64enc_queue
// Short FIFO of groups between the front and the back.
// ----------------------------------------------------------------------------
module b64enc_queue #(
  parameter int unsigned Depth = b64enc_pkg::QueueDepth
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  input  wire b64enc_pkg::group_t push_group_i,
  output      logic               full_o,
  output      logic               valid_o,
  output      b64enc_pkg::group_t group_o,
  input  wire logic               pop_i
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  b64enc_pkg::group_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == FullCnt);
  assign valid_o = (cnt_q != '0);
  assign group_o = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_group_i;
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/b64enc_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// b64enc_back
// Walks the head group one sextet per cycle, unless stalled, into a registered
// output beat, substituting '=' for padded positions.
// ----------------------------------------------------------------------------
module b64enc_back (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  q_valid_i,
  input  wire b64enc_pkg::group_t    q_group_i,
  output      b64enc_pkg::back_stat_t stat_o,
  output      logic                  out_valid_o,
  input  wire logic                  out_ready_i,
  output      b64enc_pkg::out_beat_t out_beat_o
);

  logic [1:0]            idx_q;
  logic                  out_valid_q;
  b64enc_pkg::out_beat_t out_q, out_d;
  logic                  load;
  logic [5:0]            sextet;
  logic                  is_pad;

  assign load   = q_valid_i && (!out_valid_q || out_ready_i);
  assign stat_o.pop      = load && (idx_q == 2'd3);
  assign stat_o.char_idx = idx_q;

  // Select the current sextet and its character
  always_comb begin
    case (idx_q)
      2'd0:    sextet = q_group_i.bits[23:18];
      2'd1:    sextet = q_group_i.bits[17:12];
      2'd2:    sextet = q_group_i.bits[11:6];
      default: sextet = q_group_i.bits[5:0];
    endcase
    is_pad = ({1'b0, idx_q} + {1'b0, q_group_i.pad_cnt}) > 3'd3;
    out_d.out_char  = is_pad ? b64enc_pkg::PadChar : b64enc_pkg::sextet_char(sextet);
    out_d.last_char = q_group_i.last && (idx_q == 2'd3);
  end

  // Character index and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        idx_q       <= idx_q + 2'd1;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Output beat register
  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_q;

endmodule
`default_nettype wire

// File: hw/rtl/base64_stream_encoder.sv
// Order: a byte that closes a group is written into the queue, then its
//   first character is registered into the output beat; the rest follow
//   one per cycle unless stalled.
// Throughput: one character per cycle from the output register, unless stalled.
// Reset (async, active low) clears the pending count, queue pointers, the
//   character index and the output valid.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// base64_stream_encoder
// Streaming base64 encoder: front groups bytes, queue decouples, back emits.
// ----------------------------------------------------------------------------
module base64_stream_encoder #(
  parameter int unsigned QueueDepth = b64enc_pkg::QueueDepth
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output      logic                  in_ready_o,
  input  wire b64enc_pkg::in_beat_t  in_beat_i,
  output      logic                  out_valid_o,
  input  wire logic                  out_ready_i,
  output      b64enc_pkg::out_beat_t out_beat_o
);

  logic                   push;
  b64enc_pkg::group_t     push_group;
  logic                   q_full;
  logic                   q_valid;
  b64enc_pkg::group_t     q_group;
  b64enc_pkg::back_stat_t back_stat;

  // Byte intake and grouping
  b64enc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_beat_i    (in_beat_i),
    .push_o       (push),
    .push_group_o (push_group),
    .full_i       (q_full)
  );

  // Group queue
  b64enc_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_group_i (push_group),
    .full_o       (q_full),
    .valid_o      (q_valid),
    .group_o      (q_group),
    .pop_i        (back_stat.pop)
  );

  // Character emission
  b64enc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_group_i   (q_group),
    .stat_o      (back_stat),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_beat_o  (out_beat_o)
  );

`ifndef SYNTHESIS
  // A group is only retired when the queue holds one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    back_stat.pop |-> q_valid)
    else $error("group popped from empty queue");

  // The front never pushes into a full queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !q_full)
    else $error("group pushed into full queue");

  // A pending end-of-message character is the fourth of its group
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_beat_o.last_char) |-> (back_stat.char_idx == 2'd0))
    else $error("end marker not on fourth character");

  // An accepted final byte always leads to a group in the queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && in_beat_i.end_of_message) |=> q_valid)
    else $error("final byte produced no group");
`endif

endmodule
`default_nettype wire

// File: test/tb_base64_stream_encoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_base64_stream_encoder
// Self-checking bench for the streaming base64 encoder. It starts with a
// short table of directed messages: all-zero and all-one groups of one, two
// and three bytes, and a known text. Random messages follow, in three idling
// phases, one of them with a long output stall. A behavioral encoder predicts
// every character and its end marker, but typed rows supply their own, and
// each output beat is compared against the oldest expectation.
// ----------------------------------------------------------------------------
module tb_base64_stream_encoder;

  localparam int unsigned IdleLimit = 3000;  // cycles without any beat
  localparam int unsigned TailWait  = 20;    // drain margin at the end

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_ready_o;
  b64enc_pkg::in_beat_t  in_beat_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  b64enc_pkg::out_beat_t out_beat_o;

  base64_stream_encoder dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_beat_i   (in_beat_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_beat_o  (out_beat_o)
  );

  // Directed row: one input beat, optionally with its four characters typed in
  typedef struct {
    b64enc_pkg::in_beat_t beat;
    bit                   typed;
    logic [31:0]          chars;
  } dir_row_t;

  dir_row_t              dir_rows[$];
  b64enc_pkg::out_beat_t expected_chars[$];
  b64enc_pkg::out_beat_t new_chars[$];

  // Encoder state of the predictor
  logic [1:0] held_cnt;
  logic [7:0] held_bytes [2];

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned hold_left;
  int unsigned idle_cycles;
  int unsigned errors;
  int unsigned bytes_sent;
  int unsigned msgs_sent;
  int unsigned chars_seen;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Sextet to character of the standard alphabet
  function automatic logic [7:0] b64_char(input logic [5:0] v);
    string tbl = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
    return tbl[v];
  endfunction

  function automatic void push_char(input logic [7:0] c, input logic last);
    new_chars.push_back('{out_char: c, last_char: last});
  endfunction

  // Predict the characters one accepted byte causes, updating the held state
  function automatic void encode_byte(input b64enc_pkg::in_beat_t b);
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic       eom;
    new_chars.delete();
    eom = b.end_of_message;
    if (held_cnt >= 2'd2) begin
      // third byte closes the group
      b0 = held_bytes[0];
      b1 = held_bytes[1];
      b2 = b.data_byte;
      push_char(b64_char(b0[7:2]), 1'b0);
      push_char(b64_char({b0[1:0], b1[7:4]}), 1'b0);
      push_char(b64_char({b1[3:0], b2[7:6]}), 1'b0);
      push_char(b64_char(b2[5:0]), eom);
      held_cnt = 2'd0;
    end else begin
      held_bytes[held_cnt[0]] = b.data_byte;
      held_cnt = held_cnt + 2'd1;
      if (eom) begin
        // partial group: zero-fill, then pad to four
        b0 = held_bytes[0];
        b1 = (held_cnt == 2'd2) ? held_bytes[1] : 8'h00;
        push_char(b64_char(b0[7:2]), 1'b0);
        push_char(b64_char({b0[1:0], b1[7:4]}), 1'b0);
        if (held_cnt == 2'd2) begin
          push_char(b64_char({b1[3:0], 2'b00}), 1'b0);
          push_char(b64enc_pkg::PadChar, 1'b1);
        end else begin
          push_char(b64enc_pkg::PadChar, 1'b0);
          push_char(b64enc_pkg::PadChar, 1'b1);
        end
        held_cnt = 2'd0;
      end
    end
  endfunction

  function automatic void add_row(input logic [7:0] d, input logic eom, input bit typed,
                                  input logic [31:0] chars);
    dir_row_t r;
    r.beat  = '{data_byte: d, end_of_message: eom};
    r.typed = typed;
    r.chars = chars;
    dir_rows.push_back(r);
  endfunction

  // Offer one beat (after a random gap), wait for acceptance, queue expectations
  task automatic send_beat(input b64enc_pkg::in_beat_t b, input bit typed,
                           input logic [31:0] chars);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_beat_i  <= b;
    do @(posedge clk_i); while (!in_ready_o);
    encode_byte(b);
    if (typed) begin
      for (int i = 0; i < 4; i++) begin
        expected_chars.push_back('{out_char: chars[31 - 8 * i -: 8], last_char: (i == 3)});
      end
    end else begin
      foreach (new_chars[i]) expected_chars.push_back(new_chars[i]);
    end
    bytes_sent++;
    if (b.end_of_message) msgs_sent++;
    @(negedge clk_i);
  endtask

  // One message of len random bytes
  task automatic send_message(input int unsigned len);
    b64enc_pkg::in_beat_t b;
    for (int unsigned i = 0; i < len; i++) begin
      b.data_byte      = 8'($urandom);
      b.end_of_message = (i == len - 1);
      send_beat(b, 1'b0, '0);
    end
  endtask

  task automatic random_phase(input int unsigned n_bytes);
    int unsigned start;
    int unsigned len;
    start = bytes_sent;
    while (bytes_sent - start < n_bytes) begin
      len = ($urandom_range(99) < 80) ? $urandom_range(6, 1) : $urandom_range(40, 7);
      send_message(len);
    end
  endtask

  // Sender pauses until every predicted character has come out
  task automatic drain;
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (expected_chars.size() != 0) @(negedge clk_i);
  endtask

  // Receiver: random ready, or a counted hold-off when requested
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        out_ready_i <= 1'b0;
        hold_left = hold_left - 1;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Output check against the oldest expectation
  always @(posedge clk_i) begin
    b64enc_pkg::out_beat_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      chars_seen++;
      if (expected_chars.size() == 0) begin
        $error("unexpected beat: out_char %h last_char %b", out_beat_o.out_char,
               out_beat_o.last_char);
        errors++;
      end else begin
        e = expected_chars.pop_front();
        if (out_beat_o.out_char !== e.out_char) begin
          $error("out_char: expected %h, got %h", e.out_char, out_beat_o.out_char);
          errors++;
        end
        if (out_beat_o.last_char !== e.last_char) begin
          $error("last_char: expected %b, got %b", e.last_char, out_beat_o.last_char);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles with no beat on either side
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IdleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Main sequence
  initial begin
    in_valid_i    = 1'b0;
    in_beat_i     = '0;
    rst_ni        = 1'b0;
    held_cnt      = 2'd0;
    held_bytes[0] = 8'h00;
    held_bytes[1] = 8'h00;
    hold_left     = 0;
    idle_cycles   = 0;
    errors        = 0;
    bytes_sent    = 0;
    msgs_sent     = 0;
    chars_seen    = 0;
    send_idle_pct = 21;
    recv_idle_pct = 62;

    // extremes of one, two and three byte groups, then a known text
    add_row(8'h00, 1'b1, 1'b1, "AA==");
    add_row(8'hFF, 1'b1, 1'b1, "/w==");
    add_row(8'h00, 1'b0, 1'b0, '0);
    add_row(8'h00, 1'b1, 1'b1, "AAA=");
    add_row(8'hFF, 1'b0, 1'b0, '0);
    add_row(8'hFF, 1'b1, 1'b1, "//8=");
    add_row(8'h00, 1'b0, 1'b0, '0);
    add_row(8'h00, 1'b0, 1'b0, '0);
    add_row(8'h00, 1'b1, 1'b1, "AAAA");
    add_row(8'hFF, 1'b0, 1'b0, '0);
    add_row(8'hFF, 1'b0, 1'b0, '0);
    add_row(8'hFF, 1'b1, 1'b1, "////");
    add_row("M", 1'b0, 1'b0, '0);
    add_row("a", 1'b0, 1'b0, '0);
    add_row("n", 1'b0, 1'b0, '0);
    add_row("M", 1'b1, 1'b1, "TQ==");
    add_row(8'hAA, 1'b0, 1'b0, '0);
    add_row(8'h55, 1'b1, 1'b0, '0);
    add_row(8'h80, 1'b0, 1'b0, '0);
    add_row(8'h01, 1'b0, 1'b0, '0);
    add_row(8'h7F, 1'b1, 1'b0, '0);

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[i]) send_beat(dir_rows[i].beat, dir_rows[i].typed, dir_rows[i].chars);

    // sender idles lightly, receiver heavily
    random_phase(140);
    drain();

    // swap the idling
    send_idle_pct = 62;
    recv_idle_pct = 21;
    random_phase(150);

    // no idling; a long output stall while a long message is offered
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_left     = 250;
    send_message(40);
    random_phase(120);
    drain();

    repeat (TailWait) @(posedge clk_i);

    $display("Encoded %0d bytes in %0d messages, %0d characters checked", bytes_sent,
             msgs_sent, chars_seen);
    $display("Covered padded and full final groups under both idling mixes and a long stall");
    if (errors == 0 && expected_chars.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
